FILE: sv/mck_pkg.sv
// mck_pkg: shared constants, types and lookup functions for the morse code keyer
// used by every module of the keyer; no dependencies
`timescale 1ns / 1ps

package mck_pkg;

  // queue sizing
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // field and datapath widths
  localparam int CODE_W  = 6;
  localparam int PAT_W   = 5;
  localparam int LEN_W   = 3;
  localparam int UNIT_W  = 16;
  localparam int TICK_W  = 18;
  localparam int COUNT_W = 5;

  // configuration register
  localparam logic              REG_DOT_TICKS   = 1'b0;
  localparam logic [UNIT_W-1:0] DOT_TICKS_RESET = 16'd400;

  // input opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_CHAR = 1'b1;

  // result status codes
  localparam logic [1:0] ST_TICK    = 2'd0;
  localparam logic [1:0] ST_QUEUED  = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;
  localparam logic [1:0] ST_DROPPED = 2'd3;

  // character code: digits 0..9, letters 10..35
  localparam logic [CODE_W-1:0] CODE_LETTER_BASE = 6'd10;

  // queue status seen by the keyer
  typedef struct packed {
    logic              nonempty;
    logic [CODE_W-1:0] head_code;
  } q_stat_t;

  // one morse symbol: element bits (bit 0 first, 1 = dash) and element count
  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic [LEN_W-1:0] len;
  } morse_t;

  // decoded character byte
  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
  } char_dec_t;

  // morse symbol table, unknown codes fall back to digit zero
  function automatic morse_t morse_lookup(input logic [CODE_W-1:0] code);
    morse_t m;
    case (code)
      6'd0:  m = '{pattern: 5'b11111, len: 3'd5};
      6'd1:  m = '{pattern: 5'b11110, len: 3'd5};
      6'd2:  m = '{pattern: 5'b11100, len: 3'd5};
      6'd3:  m = '{pattern: 5'b11000, len: 3'd5};
      6'd4:  m = '{pattern: 5'b10000, len: 3'd5};
      6'd5:  m = '{pattern: 5'b00000, len: 3'd5};
      6'd6:  m = '{pattern: 5'b00001, len: 3'd5};
      6'd7:  m = '{pattern: 5'b00011, len: 3'd5};
      6'd8:  m = '{pattern: 5'b00111, len: 3'd5};
      6'd9:  m = '{pattern: 5'b01111, len: 3'd5};
      6'd10: m = '{pattern: 5'b00010, len: 3'd2};  // A
      6'd11: m = '{pattern: 5'b00001, len: 3'd4};  // B
      6'd12: m = '{pattern: 5'b00101, len: 3'd4};  // C
      6'd13: m = '{pattern: 5'b00001, len: 3'd3};  // D
      6'd14: m = '{pattern: 5'b00000, len: 3'd1};  // E
      6'd15: m = '{pattern: 5'b00100, len: 3'd4};  // F
      6'd16: m = '{pattern: 5'b00011, len: 3'd3};  // G
      6'd17: m = '{pattern: 5'b00000, len: 3'd4};  // H
      6'd18: m = '{pattern: 5'b00000, len: 3'd2};  // I
      6'd19: m = '{pattern: 5'b01110, len: 3'd4};  // J
      6'd20: m = '{pattern: 5'b00101, len: 3'd3};  // K
      6'd21: m = '{pattern: 5'b00010, len: 3'd4};  // L
      6'd22: m = '{pattern: 5'b00011, len: 3'd2};  // M
      6'd23: m = '{pattern: 5'b00001, len: 3'd2};  // N
      6'd24: m = '{pattern: 5'b00111, len: 3'd3};  // O
      6'd25: m = '{pattern: 5'b00110, len: 3'd4};  // P
      6'd26: m = '{pattern: 5'b01011, len: 3'd4};  // Q
      6'd27: m = '{pattern: 5'b00010, len: 3'd3};  // R
      6'd28: m = '{pattern: 5'b00000, len: 3'd3};  // S
      6'd29: m = '{pattern: 5'b00001, len: 3'd1};  // T
      6'd30: m = '{pattern: 5'b00100, len: 3'd3};  // U
      6'd31: m = '{pattern: 5'b01000, len: 3'd4};  // V
      6'd32: m = '{pattern: 5'b00110, len: 3'd3};  // W
      6'd33: m = '{pattern: 5'b01001, len: 3'd4};  // X
      6'd34: m = '{pattern: 5'b01101, len: 3'd4};  // Y
      6'd35: m = '{pattern: 5'b00011, len: 3'd4};  // Z
      default: m = '{pattern: 5'b11111, len: 3'd5};
    endcase
    return m;
  endfunction

  // map an ascii byte to a character code, case folded
  function automatic char_dec_t decode_char(input logic [7:0] ch);
    char_dec_t d;
    d.valid = 1'b0;
    d.code  = '0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      d.valid = 1'b1;
      d.code  = CODE_W'(ch - 8'h30);
    end else if (ch >= 8'h61 && ch <= 8'h7a) begin
      d.valid = 1'b1;
      d.code  = CODE_LETTER_BASE + CODE_W'(ch - 8'h61);
    end else if (ch >= 8'h41 && ch <= 8'h5a) begin
      d.valid = 1'b1;
      d.code  = CODE_LETTER_BASE + CODE_W'(ch - 8'h41);
    end
    return d;
  endfunction

endpackage

FILE: sv/morse_code_keyer_top.sv
// Morse code keyer. Each input transaction is either one time tick or one character byte;
// letters (either case) and digits go into a 16-entry queue, anything else is ignored, and a
// valid character arriving on a full queue is dropped. On ticks the lamp is keyed with
// standard timing: dot one unit, dash three, one unit dark between elements, three after a
// character; the unit length in ticks is the dot_ticks register (byte address 0, zero acts
// as one). Every transaction returns exactly one result transaction. The block takes one
// transaction per clock cycle while out_stall is low; a transaction is captured in the input
// register when it is accepted, and its result is loaded into the result register when the
// input register advances; the queue and the element sequencer update between those registers,
// and a stalled result holds the input register, so at most two transactions are in flight.
// depends on mck_pkg, mck_cfg, mck_queue, mck_keyer
`timescale 1ns / 1ps

module morse_code_keyer_top (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [7:0]  in_char_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_lamp_on,
  output logic        out_busy_res,
  output logic [4:0]  out_queued_count,
  output logic [1:0]  out_status,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                        s1_valid_r;
  logic                        s1_op_r;
  logic [7:0]                  s1_char_r;
  logic                        s1_adv;
  logic                        in_take;

  logic                        out_valid_r;
  logic                        out_lamp_r;
  logic                        out_busy_r;
  logic [4:0]                  out_count_r;
  logic [1:0]                  out_status_r;

  logic [mck_pkg::UNIT_W-1:0]  unit_len;
  mck_pkg::q_stat_t            q_stat;
  mck_pkg::char_dec_t          dec;
  logic                        is_tick;
  logic                        is_char;
  logic                        q_full;
  logic                        push;
  logic                        pop;
  logic [mck_pkg::CNT_W-1:0]   fill_nxt;
  logic                        lamp_nxt;
  logic                        busy_nxt;
  logic [1:0]                  status_nxt;

  // handshake between the two register stages
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= in_opcode;
      s1_char_r <= in_char_byte;
    end
  end

  // character classification
  assign is_tick = (s1_op_r == mck_pkg::OP_TICK);
  assign is_char = (s1_op_r == mck_pkg::OP_CHAR);
  assign dec     = mck_pkg::decode_char(s1_char_r);
  assign push    = is_char && dec.valid && !q_full;

  always_comb begin
    status_nxt = mck_pkg::ST_TICK;
    if (is_char) begin
      if (!dec.valid) begin
        status_nxt = mck_pkg::ST_IGNORED;
      end else if (q_full) begin
        status_nxt = mck_pkg::ST_DROPPED;
      end else begin
        status_nxt = mck_pkg::ST_QUEUED;
      end
    end
  end

  // configuration register
  mck_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .unit_len (unit_len)
  );

  // character queue
  mck_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (s1_adv),
    .push      (push),
    .push_code (dec.code),
    .pop       (pop),
    .q_stat    (q_stat),
    .full      (q_full),
    .fill_nxt  (fill_nxt)
  );

  // element sequencer
  mck_keyer u_keyer (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (s1_adv),
    .tick     (is_tick),
    .unit_len (unit_len),
    .q_stat   (q_stat),
    .pop      (pop),
    .lamp_nxt (lamp_nxt),
    .busy_nxt (busy_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_lamp_r   <= lamp_nxt;
      out_busy_r   <= busy_nxt;
      out_count_r  <= mck_pkg::COUNT_W'(fill_nxt);
      out_status_r <= status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_lamp_on      = out_lamp_r;
  assign out_busy_res     = out_busy_r;
  assign out_queued_count = out_count_r;
  assign out_status       = out_status_r;

endmodule

FILE: sv/mck_cfg.sv
// mck_cfg: apb-style configuration register holding the morse unit length
// depends on mck_pkg
`timescale 1ns / 1ps

module mck_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [mck_pkg::UNIT_W-1:0] unit_len
);

  logic [mck_pkg::UNIT_W-1:0] dot_ticks_r;
  logic                       reg_idx;
  logic                       wr_en;

  // word decode, byte lanes within the word are not distinguished
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready && (reg_idx == mck_pkg::REG_DOT_TICKS);

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_ticks_r <= mck_pkg::DOT_TICKS_RESET;
    end else if (wr_en) begin
      dot_ticks_r <= pwdata[mck_pkg::UNIT_W-1:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (reg_idx == mck_pkg::REG_DOT_TICKS) begin
      prdata = 32'(dot_ticks_r);
    end
  end

  // a zero unit counts as one tick
  assign unit_len = (dot_ticks_r == '0) ? mck_pkg::UNIT_W'(1) : dot_ticks_r;

endmodule

FILE: sv/mck_queue.sv
// mck_queue: character code fifo in flip-flops with head, tail and fill count
// depends on mck_pkg
`timescale 1ns / 1ps

module mck_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        push,
  input  logic [mck_pkg::CODE_W-1:0]  push_code,
  input  logic                        pop,
  output mck_pkg::q_stat_t            q_stat,
  output logic                        full,
  output logic [mck_pkg::CNT_W-1:0]   fill_nxt
);

  logic [mck_pkg::CODE_W-1:0] mem_r [mck_pkg::QUEUE_DEPTH];
  logic [mck_pkg::PTR_W-1:0]  head_r, head_nxt;
  logic [mck_pkg::PTR_W-1:0]  tail_r, tail_nxt;
  logic [mck_pkg::CNT_W-1:0]  fill_r;

  localparam logic [mck_pkg::PTR_W-1:0] LAST_IDX = mck_pkg::PTR_W'(mck_pkg::QUEUE_DEPTH - 1);
  localparam logic [mck_pkg::CNT_W-1:0] DEPTH_CNT = mck_pkg::CNT_W'(mck_pkg::QUEUE_DEPTH);

  // status toward the keyer
  assign q_stat.nonempty  = (fill_r != '0);
  assign q_stat.head_code = mem_r[head_r];
  assign full             = (fill_r == DEPTH_CNT);

  // pointer and count update, push and pop never coincide
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (push) begin
      tail_nxt = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
      fill_nxt = fill_r + 1'b1;
    end else if (pop) begin
      head_nxt = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
      fill_nxt = fill_r - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else if (en) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (en && push) begin
      mem_r[tail_r] <= push_code;
    end
  end

endmodule

FILE: sv/mck_keyer.sv
// mck_keyer: element sequencer that keys the lamp in morse timing on each tick
// depends on mck_pkg
`timescale 1ns / 1ps

module mck_keyer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        tick,
  input  logic [mck_pkg::UNIT_W-1:0]  unit_len,
  input  mck_pkg::q_stat_t            q_stat,
  output logic                        pop,
  output logic                        lamp_nxt,
  output logic                        busy_nxt
);

  logic                        active_r, active_nxt;
  logic                        mark_r, mark_nxt;
  logic [mck_pkg::PAT_W-1:0]   pat_r, pat_nxt;
  logic [mck_pkg::LEN_W-1:0]   left_r, left_nxt;
  logic [mck_pkg::TICK_W-1:0]  ticks_r, ticks_nxt;

  logic [mck_pkg::TICK_W-1:0]  unit1;
  logic [mck_pkg::TICK_W-1:0]  unit3;
  mck_pkg::morse_t             sym;

  // one and three unit phase lengths
  assign unit1 = mck_pkg::TICK_W'(unit_len);
  assign unit3 = (unit1 << 1) + unit1;
  assign sym   = mck_pkg::morse_lookup(q_stat.head_code);

  // phase sequencing for one tick
  always_comb begin
    logic                       act1;
    logic                       mark1;
    logic [mck_pkg::TICK_W-1:0] tl1;
    logic                       start_cur;
    logic [mck_pkg::PAT_W-1:0]  src_pat;
    logic [mck_pkg::LEN_W-1:0]  src_left;

    act1      = active_r;
    mark1     = mark_r;
    tl1       = ticks_r;
    start_cur = 1'b0;

    // count down the current phase
    if (tick && active_r) begin
      tl1 = (ticks_r != '0) ? ticks_r - 1'b1 : '0;
      if (tl1 == '0) begin
        if (mark_r) begin
          mark1 = 1'b0;
          tl1   = (left_r != '0) ? unit1 : unit3;
        end else if (left_r != '0) begin
          start_cur = 1'b1;
        end else begin
          act1 = 1'b0;
        end
      end
    end

    // idle keyer takes the next queued character on the same tick
    pop      = tick && !act1 && q_stat.nonempty;
    src_pat  = pop ? sym.pattern : pat_r;
    src_left = pop ? sym.len : left_r;

    if (start_cur || pop) begin
      active_nxt = 1'b1;
      mark_nxt   = 1'b1;
      pat_nxt    = src_pat >> 1;
      left_nxt   = (src_left != '0) ? src_left - 1'b1 : '0;
      ticks_nxt  = src_pat[0] ? unit3 : unit1;
    end else begin
      active_nxt = act1;
      mark_nxt   = mark1;
      pat_nxt    = pat_r;
      left_nxt   = left_r;
      ticks_nxt  = tl1;
    end
  end

  assign lamp_nxt = mark_nxt && active_nxt;
  assign busy_nxt = active_nxt;

  // keyer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      mark_r   <= 1'b0;
      pat_r    <= '0;
      left_r   <= '0;
      ticks_r  <= '0;
    end else if (en) begin
      active_r <= active_nxt;
      mark_r   <= mark_nxt;
      pat_r    <= pat_nxt;
      left_r   <= left_nxt;
      ticks_r  <= ticks_nxt;
    end
  end

endmodule
